[rtl/fdfs_pkg.sv]
// Shared types and constants for the framed decimal field summer.
// Used by the front end, the token queue, the back end and the top level.
`default_nettype none

package fdfs_pkg;

  localparam int unsigned MAX_DIGITS = 9;
  localparam int unsigned NUM_W      = 30;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned SUM_W      = 32;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned HDR_W      = 3;
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [HDR_W-1:0] HDR_LEN = HDR_W'(4);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_EQUAL = 8'h3d;
  localparam logic [7:0] CHAR_F     = 8'h46;
  localparam logic [7:0] CHAR_I     = 8'h49;
  localparam logic [7:0] CHAR_N     = 8'h4e;

  typedef enum logic [1:0] {
    TK_NONE,
    TK_DIGIT,
    TK_DELIM
  } tok_kind_e;

  // One classified item handed from the front end to the back end.
  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
    logic       last;
    logic       fin;
  } tok_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

  function automatic logic [7:0] fin_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = CHAR_F;
      2'd1:    c = CHAR_I;
      2'd2:    c = CHAR_N;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/fdfs_front.sv]
// Front end: parses the length header, counts payload bytes and classifies each
// payload byte into a token; also tracks the "FIN" match. Depends on fdfs_pkg.
`default_nettype none

module fdfs_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [7:0]        stream_byte_i,
  input  wire logic              fifo_full_i,
  output fdfs_pkg::tok_t         tok_o,
  output logic                   push_o
);
  import fdfs_pkg::*;

  logic [HDR_W-1:0] hdr_q, hdr_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] left_q, left_d;
  logic [1:0]       prog_q, prog_d;
  logic             ok_q, ok_d;
  logic             accept;
  logic [LEN_W-1:0] len_shift;
  logic             last;

  assign accept    = in_valid_i && !fifo_full_i;
  assign len_shift = {len_q[LEN_W-9:0], stream_byte_i};
  assign last      = (left_q == LEN_W'(1));

  always_comb begin
    hdr_d  = hdr_q;
    len_d  = len_q;
    left_d = left_q;
    prog_d = prog_q;
    ok_d   = ok_q;
    push_o = 1'b0;
    tok_o  = '{kind: TK_NONE, digit: 4'd0, last: 1'b0, fin: 1'b0};
    if (accept) begin
      if (hdr_q < HDR_LEN) begin
        len_d = len_shift;
        hdr_d = hdr_q + HDR_W'(1);
        if (hdr_q == HDR_LEN - HDR_W'(1)) begin
          if (len_shift == '0) begin
            // empty frame: emit a bare end marker
            push_o     = 1'b1;
            tok_o.last = 1'b1;
            len_d      = '0;
            hdr_d      = '0;
          end else begin
            left_d = len_shift;
          end
        end
      end else begin
        push_o = 1'b1;
        if (stream_byte_i >= CHAR_ZERO && stream_byte_i <= CHAR_NINE) begin
          tok_o.kind  = TK_DIGIT;
          tok_o.digit = 4'(stream_byte_i - CHAR_ZERO);
        end else if (stream_byte_i == CHAR_COMMA || stream_byte_i == CHAR_EQUAL) begin
          tok_o.kind = TK_DELIM;
        end
        if (prog_q != 2'd3 && stream_byte_i == fin_char(prog_q)) begin
          prog_d = prog_q + 2'd1;
        end else begin
          ok_d = 1'b0;
        end
        tok_o.last = last;
        tok_o.fin  = last && ok_d && (prog_d == 2'd3);
        left_d     = left_q - LEN_W'(1);
        if (last) begin
          hdr_d  = '0;
          len_d  = '0;
          left_d = '0;
          prog_d = '0;
          ok_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q  <= '0;
      len_q  <= '0;
      left_q <= '0;
      prog_q <= '0;
      ok_q   <= 1'b1;
    end else begin
      hdr_q  <= hdr_d;
      len_q  <= len_d;
      left_q <= left_d;
      prog_q <= prog_d;
      ok_q   <= ok_d;
    end
  end

endmodule

`default_nettype wire

[rtl/fdfs_fifo.sv]
// Short token queue between front and back end so each side stalls on its own.
// Depends on fdfs_pkg for the token type and depth.
`default_nettype none

module fdfs_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire fdfs_pkg::tok_t  tok_i,
  input  wire logic            pop_i,
  output fdfs_pkg::tok_t       tok_o,
  output fdfs_pkg::fifo_st_t   st_o
);
  import fdfs_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [PTR_W:0]   CNT_FULL = (PTR_W + 1)'(FIFO_DEPTH);

  tok_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign st_o.full  = (cnt_q == CNT_FULL);
  assign st_o.empty = (cnt_q == '0);
  assign do_push    = push_i && !st_o.full;
  assign do_pop     = pop_i && !st_o.empty;
  assign tok_o      = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ((wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1)) : wr_q;
    rd_d  = do_pop  ? ((rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1)) : rd_q;
    cnt_d = cnt_q + (PTR_W + 1)'(do_push) - (PTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= tok_i;
    end
  end

endmodule

`default_nettype wire

[rtl/fdfs_back.sv]
// Back end: builds pending numbers, accumulates the frame sum and holds the
// result in an output register. Depends on fdfs_pkg.
`default_nettype none

module fdfs_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire fdfs_pkg::tok_t         tok_i,
  input  wire logic                   empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [31:0]          frame_sum_o,
  output logic                        is_finish_o
);
  import fdfs_pkg::*;

  logic [NUM_W-1:0] pend_q, pend_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             vld_q, vld_d;
  logic [SUM_W-1:0] res_sum_q;
  logic             res_fin_q;
  logic             slot_free, load;
  logic [NUM_W+3:0] times_ten;
  logic [SUM_W-1:0] sum_n;

  assign slot_free = !vld_q || !out_stall_i;
  assign pop_o     = !empty_i && (!tok_i.last || slot_free);
  assign load      = pop_o && tok_i.last;

  // x*10 + d as two shifted adds
  assign times_ten = {1'b0, pend_q, 3'b000} + {3'b000, pend_q, 1'b0}
                   + (NUM_W + 4)'(tok_i.digit);

  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    sum_n  = sum_q;
    if (pop_o) begin
      unique case (tok_i.kind)
        TK_DIGIT: begin
          if (cnt_q < CNT_W'(MAX_DIGITS)) begin
            pend_d = times_ten[NUM_W-1:0];
            cnt_d  = cnt_q + CNT_W'(1);
          end
        end
        TK_DELIM: begin
          sum_n  = sum_q + SUM_W'(pend_q);
          pend_d = '0;
          cnt_d  = '0;
        end
        default: ;
      endcase
      sum_d = sum_n;
      if (tok_i.last) begin
        pend_d = '0;
        cnt_d  = '0;
        sum_d  = '0;
      end
    end
    vld_d = load ? 1'b1 : (slot_free ? 1'b0 : vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
      vld_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      vld_q  <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_sum_q <= sum_n;
      res_fin_q <= tok_i.fin;
    end
  end

  assign out_valid_o = vld_q;
  assign frame_sum_o = res_sum_q;
  assign is_finish_o = res_fin_q;

endmodule

`default_nettype wire

[rtl/framed_decimal_field_summer_top.sv]
// Top level of the framed decimal field summer: front end, token queue and
// back end. Depends on fdfs_pkg, fdfs_front, fdfs_fifo and fdfs_back.
//
//   channel | ports                                | handshake
//   --------+--------------------------------------+------------------------
//   in      | stream_byte_i[7:0]                   | in_valid_i / in_stall_o
//   out     | frame_sum_o[31:0] (signed), is_finish_o | out_valid_o / out_stall_i
//
// One byte is taken per cycle while in_stall_o is low; the sum update (shift-add
// times ten) sits in the back end and a two-entry token queue decouples it from
// header parsing. A frame end is queued, then its sum loads the output register.
// Reset clears all frame state; the queue and output register come up empty.
// in_stall_o rises only when the token queue is full, i.e. when the output
// register is held by out_stall_i and the queue has filled behind it.
`default_nettype none

module framed_decimal_field_summer_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         stream_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      frame_sum_o,
  output logic                    is_finish_o
);
  import fdfs_pkg::*;

  tok_t     push_tok, head_tok;
  logic     push, pop;
  fifo_st_t fifo_st;

  assign in_stall_o = fifo_st.full;

  fdfs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .stream_byte_i (stream_byte_i),
    .fifo_full_i   (fifo_st.full),
    .tok_o         (push_tok),
    .push_o        (push)
  );

  fdfs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .tok_i  (push_tok),
    .pop_i  (pop),
    .tok_o  (head_tok),
    .st_o   (fifo_st)
  );

  fdfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (head_tok),
    .empty_i     (fifo_st.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .frame_sum_o (frame_sum_o),
    .is_finish_o (is_finish_o)
  );

  a_fifo_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_st.full && fifo_st.empty))
    else $error("token queue flags full and empty together");

  a_no_pop_on_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head_tok.last) |-> !(out_valid_o && out_stall_i))
    else $error("frame end popped while result register is held");

  a_frame_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && head_tok.last) |=> out_valid_o)
    else $error("frame end did not load the result register");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_st.full |-> !push)
    else $error("token pushed into a full queue");

endmodule

`default_nettype wire
